[src/itra_pkg.sv]
package itra_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int RADIX_BITS  = 8;
    localparam int CHAR_BITS   = 7;
    localparam int DIGIT_BITS  = 6;
    localparam int STEP_BITS   = 8;
    localparam int DIV_STEPS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS    = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int DIGIT_IDX_W = $clog2(VALUE_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [RADIX_BITS-1:0] RADIX_MIN     = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX     = RADIX_BITS'(36);
    localparam logic [DIGIT_BITS-1:0] RADIX_DEFAULT = DIGIT_BITS'(10);
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN     = DIGIT_BITS'(10);

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 7'h41;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0]        radix;
    } item_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } text_t;

    typedef struct packed {
        logic                  negative;
        logic [DIGIT_BITS-1:0] radix;
        logic [VALUE_BITS-1:0] magnitude;
    } job_t;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_SIGN,
        BACK_DIVIDE,
        BACK_FETCH,
        BACK_EMIT
    } back_state_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] digit);
        logic [CHAR_BITS-1:0] wide;
        wide = CHAR_BITS'(digit);
        if (digit < DIGIT_TEN)
        begin
            return CHAR_ZERO + wide;
        end
        return CHAR_ALPHA + wide - CHAR_BITS'(DIGIT_TEN);
    endfunction

endpackage

[src/itra_front.sv]
module itra_front
    import itra_pkg::*;
(
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    input  logic  full,
    output logic  push,
    output job_t  job
);

    logic [VALUE_BITS-1:0] raw;

    assign raw        = item.value;
    assign item_stall = full;
    assign push       = item_valid && !full;

    always_comb
    begin
        job.negative  = raw[VALUE_BITS-1];
        job.magnitude = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
        if (item.radix < RADIX_MIN || item.radix > RADIX_MAX)
        begin
            job.radix = RADIX_DEFAULT;
        end
        else
        begin
            job.radix = item.radix[DIGIT_BITS-1:0];
        end
    end

endmodule

[src/itra_queue.sv]
module itra_queue
    import itra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic nonempty,
    output logic full
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign head     = slot_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/itra_back.sv]
module itra_back
    import itra_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  job_t  head,
    input  logic  nonempty,
    output logic  pop,
    output logic  text_valid,
    input  logic  text_stall,
    output text_t text
);

    back_state_t            state_reg, state_next;
    logic [DIGIT_BITS-1:0]  radix_reg, radix_next;
    logic [PAD_BITS-1:0]    work_reg, work_next;
    logic [DIGIT_BITS-1:0]  rem_reg, rem_next;
    logic [STEP_CNT_W-1:0]  step_reg, step_next;
    logic [DIGIT_IDX_W-1:0] wptr_reg, wptr_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    text_t                  out_reg, out_next;
    logic [DIGIT_BITS-1:0]  rd_data_reg;
    logic [DIGIT_BITS-1:0]  digit_mem [VALUE_BITS];

    logic                   mem_we;
    logic                   load_out;
    logic                   slot_free;
    logic [DIGIT_BITS-1:0]  div_rem;
    logic [PAD_BITS-1:0]    div_work;

    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DIV_STEPS - 1);

    assign slot_free  = !out_valid_reg || !text_stall;
    assign text_valid = out_valid_reg;
    assign text       = out_reg;

    // STEP_BITS quotient bits per pass, remainder stays below radix
    always_comb
    begin
        logic [DIGIT_BITS:0]   trial;
        logic [DIGIT_BITS-1:0] r;
        logic [PAD_BITS-1:0]   w;
        r = rem_reg;
        w = work_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial = {r, w[PAD_BITS-1]};
            w     = {w[PAD_BITS-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg})
            begin
                trial = trial - {1'b0, radix_reg};
                w[0]  = 1'b1;
            end
            r = trial[DIGIT_BITS-1:0];
        end
        div_rem  = r;
        div_work = w;
    end

    always_comb
    begin
        state_next = state_reg;
        radix_next = radix_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        wptr_next  = wptr_reg;
        idx_next   = idx_reg;
        out_next   = out_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        load_out   = 1'b0;

        unique case (state_reg)
            BACK_IDLE:
            begin
                if (nonempty)
                begin
                    pop        = 1'b1;
                    radix_next = head.radix;
                    work_next  = PAD_BITS'(head.magnitude);
                    rem_next   = '0;
                    step_next  = '0;
                    wptr_next  = '0;
                    state_next = head.negative ? BACK_SIGN : BACK_DIVIDE;
                end
            end
            BACK_SIGN:
            begin
                if (slot_free)
                begin
                    load_out           = 1'b1;
                    out_next.character = CHAR_MINUS;
                    out_next.last      = 1'b0;
                    state_next         = BACK_DIVIDE;
                end
            end
            BACK_DIVIDE:
            begin
                work_next = div_work;
                rem_next  = div_rem;
                if (step_reg == STEP_LAST)
                begin
                    mem_we    = 1'b1;
                    step_next = '0;
                    rem_next  = '0;
                    if (div_work == '0)
                    begin
                        idx_next   = wptr_reg;
                        state_next = BACK_FETCH;
                    end
                    else
                    begin
                        wptr_next = wptr_reg + 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            BACK_FETCH:
            begin
                state_next = BACK_EMIT;
            end
            BACK_EMIT:
            begin
                if (slot_free)
                begin
                    load_out           = 1'b1;
                    out_next.character = digit_char(rd_data_reg);
                    out_next.last      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = BACK_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !text_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[wptr_reg] <= div_rem;
        end
        rd_data_reg <= digit_mem[idx_next];
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        idx_reg   <= idx_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            step_reg      <= '0;
            wptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            wptr_reg      <= wptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/integer_to_radix_ascii_core.sv]
// Converts a signed 32-bit integer to ASCII text in radix 2 to 36 (other radix codes
// mean 10). Input channel item_valid / item_stall / item carries value and radix;
// output channel text_valid / text_stall / text carries one character per beat,
// '-' first for a negative value, then digits 0-9, A-Z most significant first,
// with last set on the final character.
// An input beat lands in a two-entry job queue, so up to two items wait while the
// converter works. The remainder divider takes 8 quotient bits per cycle over the
// 32-bit magnitude for each digit. The converter pops the job, sends the '-' of a
// negative value to the output register, divides out all digits, fetches the most
// significant digit, then sends each character through the output register.
// With the converter idle, the '-' of a negative value goes out before the digits
// are divided; for other values the first character follows the last division.
// Reset (rst_n low, asynchronous) empties the queue and drops any text in flight.
// A stalled output beat holds; the converter then waits and the queue fills,
// after which item_stall rises.
module integer_to_radix_ascii_core
    import itra_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    output logic  text_valid,
    input  logic  text_stall,
    output text_t text
);

    logic push;
    logic pop;
    logic full;
    logic nonempty;
    job_t push_job;
    job_t head;

    itra_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .full       (full),
        .push       (push),
        .job        (push_job)
    );

    itra_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty),
        .full     (full)
    );

    itra_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .nonempty   (nonempty),
        .pop        (pop),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text)
    );

endmodule
